// ===== rtl/bggm_pkg.sv =====
// bggm_pkg: shared widths, codes and types for the bounded Gaussian gene mutator.
// No dependencies; used by the channel interfaces and every RTL module.
`timescale 1ns / 1ps
`default_nettype none

package bggm_pkg;

	localparam int GENE_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = GENE_W + SAMPLE_W;
	localparam int FRAC_SHIFT = 12;
	localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
	localparam int SUM_W      = SCALED_W + 1;
	localparam int COUNT_W    = 11;
	localparam int MAX_GENES  = 1024;
	localparam int HIT_CAP_I  = (MAX_GENES < 2047) ? MAX_GENES : 2047;
	localparam logic [COUNT_W-1:0] HIT_CAP = COUNT_W'(HIT_CAP_I);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MUTATION_ENABLED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_MODE      = CFG_IDX_W'(1);

	// serial remainder unit: one quotient bit per cycle
	localparam int REM_W     = GENE_W;
	localparam int REM_CNT_W = $clog2(REM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_CHECK,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [REM_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] rem;
	} rem_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bggm_item_if.sv =====
// bggm_item_if: input channel carrying one gene with its bounds and random draws.
// Depends on bggm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bggm_item_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bggm_pkg::GENE_W-1:0]   gene_value;
	logic signed [bggm_pkg::GENE_W-1:0]   low_bound;
	logic signed [bggm_pkg::GENE_W-1:0]   high_bound;
	logic signed [bggm_pkg::GENE_W-1:0]   step_size;
	logic                                 wraps_around;
	logic                                 coin_hit;
	logic signed [bggm_pkg::SAMPLE_W-1:0] gaussian_sample;
	logic                                 last_gene;

	modport source (
		output valid, gene_value, low_bound, high_bound, step_size,
		output wraps_around, coin_hit, gaussian_sample, last_gene,
		input  ready
	);
	modport sink (
		input  valid, gene_value, low_bound, high_bound, step_size,
		input  wraps_around, coin_hit, gaussian_sample, last_gene,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bggm_result_if.sv =====
// bggm_result_if: output channel carrying one mutated gene and the genome hit count.
// Depends on bggm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bggm_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [bggm_pkg::GENE_W-1:0]  new_gene;
	logic                                gene_mutated;
	logic        [bggm_pkg::COUNT_W-1:0] mutated_total;
	logic                                last_out;

	modport source (
		output valid, new_gene, gene_mutated, mutated_total, last_out,
		input  ready
	);
	modport sink (
		input  valid, new_gene, gene_mutated, mutated_total, last_out,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bggm_cfg_if.sv =====
// bggm_cfg_if: register write channel (index and data).
// Depends on bggm_pkg for index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface bggm_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [bggm_pkg::CFG_IDX_W-1:0]         index;
	logic [bggm_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bggm_rem.sv =====
// bggm_rem: unsigned restoring remainder unit, one bit per cycle.
// Depends on bggm_pkg (rem_req_t, rem_rsp_t, REM_W).
`timescale 1ns / 1ps
`default_nettype none

module bggm_rem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bggm_pkg::rem_req_t req,
	output bggm_pkg::rem_rsp_t      rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [bggm_pkg::REM_CNT_W-1:0]     cnt_q;
	logic [bggm_pkg::REM_W-1:0]         rem_q;
	logic [bggm_pkg::REM_W-1:0]         quo_q;
	logic [bggm_pkg::REM_W-1:0]         div_q;
	logic [bggm_pkg::REM_W:0]           trial;
	logic [bggm_pkg::REM_W:0]           diff;

	assign trial = {rem_q, quo_q[bggm_pkg::REM_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= bggm_pkg::REM_CNT_W'(bggm_pkg::REM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// trial < 2*divisor, so a kept difference always fits the remainder width
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bggm_pkg::REM_W-2:0], 1'b0};
			if (!diff[bggm_pkg::REM_W])
				rem_q <= diff[bggm_pkg::REM_W-1:0];
			else
				rem_q <= trial[bggm_pkg::REM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/bounded_gaussian_gene_mutator_unit.sv =====
// bounded_gaussian_gene_mutator_unit: top level, sequencer and datapath of the mutator.
// Depends on bggm_pkg, bggm_item_if, bggm_result_if, bggm_cfg_if and bggm_rem.
//
// Usage: one gene per transfer on item; one result per gene on result, in order.
// cfg writes mutation_enabled (index 0) and bounce_mode (index 1); it is always
// ready and is meant to be written only while the unit is idle.
// item.ready is high only when the sequencer is idle, so genes are taken one at
// a time. A pass-through or empty-range gene goes from IDLE straight to OUT; a
// clamped gene passes through MUL, ADD, CHECK and OUT; a reflected or wrapped
// gene also passes through DIV, where it waits on the 32-step serial remainder
// unit, and FIX before OUT.
// The result sits in an output register: while the receiver stalls, the next
// gene is still taken and worked on, and the sequencer waits only when a second
// result is ready before the first has been taken.
// Reset clears both registers, the genome hit count and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module bounded_gaussian_gene_mutator_unit (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bggm_item_if.sink      item,
	bggm_result_if.source  result,
	bggm_cfg_if.sink       cfg
);

	localparam int GW = bggm_pkg::GENE_W;

	bggm_pkg::state_t state_q, state_d;

	logic                            en_q;
	logic                            bounce_q;
	logic [bggm_pkg::COUNT_W-1:0]    hit_count_q;

	// working registers for the gene in flight
	logic signed [GW-1:0]                  gene_q;
	logic signed [GW-1:0]                  lo_q;
	logic signed [GW-1:0]                  hi_q;
	logic signed [GW-1:0]                  step_q;
	logic signed [bggm_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                  wraps_q;
	logic signed [bggm_pkg::PROD_W-1:0]    prod_q;
	logic signed [GW-1:0]                  v_q;
	logic signed [GW-1:0]                  res_q;
	logic                                  mutated_q;
	logic [bggm_pkg::COUNT_W-1:0]          total_q;
	logic                                  last_q;
	logic                                  hi_minus_q;
	logic [GW-1:0]                         dvd_q;
	logic [GW-1:0]                         dvs_q;
	logic                                  div_go_q;

	// output register
	logic                                  out_valid_q;
	logic signed [GW-1:0]                  out_gene_q;
	logic                                  out_mut_q;
	logic [bggm_pkg::COUNT_W-1:0]          out_total_q;
	logic                                  out_last_q;

	bggm_pkg::rem_req_t rem_req;
	bggm_pkg::rem_rsp_t rem_rsp;

	logic                            item_xfer;
	logic                            empty_rng;
	logic                            counted;
	logic                            do_mut;
	logic [bggm_pkg::COUNT_W-1:0]    cnt_next;
	logic                            out_load;
	logic signed [bggm_pkg::PROD_W-1:0]   rounded;
	logic signed [bggm_pkg::SCALED_W-1:0] scaled;
	logic signed [bggm_pkg::SUM_W-1:0]    sum;
	logic signed [GW-1:0]                 sat;
	logic                                 below;
	logic                                 above;
	logic [GW:0]                          excess;
	logic [GW:0]                          span;

	assign item_xfer = item.valid && item.ready;
	assign item.ready = (state_q == bggm_pkg::ST_IDLE);
	assign cfg.ready  = 1'b1;

	assign empty_rng = (item.low_bound >= item.high_bound);
	assign counted   = en_q && !empty_rng && item.coin_hit;
	assign do_mut    = counted && (item.step_size > 0);
	assign cnt_next  = (counted && (hit_count_q < bggm_pkg::HIT_CAP))
		? hit_count_q + 1'b1 : hit_count_q;

	// round half up, then floor shift back to Q16.16
	assign rounded = prod_q + bggm_pkg::PROD_W'(2048);
	assign scaled  = rounded[bggm_pkg::PROD_W-1:bggm_pkg::FRAC_SHIFT];
	assign sum     = bggm_pkg::SUM_W'(gene_q) + bggm_pkg::SUM_W'(scaled);

	always_comb begin
		if (sum[bggm_pkg::SUM_W-1:GW-1] == '0 || sum[bggm_pkg::SUM_W-1:GW-1] == '1)
			sat = sum[GW-1:0];
		else if (sum[bggm_pkg::SUM_W-1])
			sat = {1'b1, {(GW-1){1'b0}}};
		else
			sat = {1'b0, {(GW-1){1'b1}}};
	end

	assign below = (v_q < lo_q);
	assign above = (v_q > hi_q);
	// both fit GW bits unsigned; the top bit is dropped
	assign excess = below ? ({lo_q[GW-1], lo_q} - {v_q[GW-1], v_q})
		: ({v_q[GW-1], v_q} - {hi_q[GW-1], hi_q});
	assign span  = {hi_q[GW-1], hi_q} - {lo_q[GW-1], lo_q};

	assign rem_req.start    = div_go_q;
	assign rem_req.dividend = dvd_q;
	assign rem_req.divisor  = dvs_q;

	bggm_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bggm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		out_load      = 1'b0;
		unique case (state_q)
			bggm_pkg::ST_IDLE: begin
				if (item_xfer)
					state_d = do_mut ? bggm_pkg::ST_MUL : bggm_pkg::ST_OUT;
			end
			bggm_pkg::ST_MUL:   state_d = bggm_pkg::ST_ADD;
			bggm_pkg::ST_ADD:   state_d = bggm_pkg::ST_CHECK;
			bggm_pkg::ST_CHECK: begin
				if ((below || above) && (wraps_q || bounce_q))
					state_d = bggm_pkg::ST_DIV;
				else
					state_d = bggm_pkg::ST_OUT;
			end
			bggm_pkg::ST_DIV: begin
				if (rem_rsp.done)
					state_d = bggm_pkg::ST_FIX;
			end
			bggm_pkg::ST_FIX:   state_d = bggm_pkg::ST_OUT;
			bggm_pkg::ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = bggm_pkg::ST_IDLE;
				end
			end
			default:            state_d = bggm_pkg::ST_IDLE;
		endcase
	end

	// remainder unit is started on entry to DIV from a registered flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_go_q <= 1'b0;
		else
			div_go_q <= (state_q == bggm_pkg::ST_CHECK) && (state_d == bggm_pkg::ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			bounce_q    <= 1'b0;
			hit_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					bggm_pkg::REG_MUTATION_ENABLED: en_q     <= cfg.data[0];
					bggm_pkg::REG_BOUNCE_MODE:      bounce_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (item_xfer)
				hit_count_q <= item.last_gene ? '0 : cnt_next;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			gene_q    <= item.gene_value;
			lo_q      <= item.low_bound;
			hi_q      <= item.high_bound;
			step_q    <= item.step_size;
			sample_q  <= item.gaussian_sample;
			wraps_q   <= item.wraps_around;
			res_q     <= (en_q && empty_rng) ? item.low_bound : item.gene_value;
			mutated_q <= counted;
			total_q   <= item.last_gene ? cnt_next : '0;
			last_q    <= item.last_gene;
		end
		if (state_q == bggm_pkg::ST_MUL)
			prod_q <= bggm_pkg::PROD_W'(sample_q) * bggm_pkg::PROD_W'(step_q);
		if (state_q == bggm_pkg::ST_ADD)
			v_q <= sat;
		if (state_q == bggm_pkg::ST_CHECK) begin
			hi_minus_q <= (below == wraps_q);
			dvd_q      <= excess[GW-1:0];
			dvs_q      <= span[GW-1:0];
			if (below)
				res_q <= lo_q;
			else if (above)
				res_q <= hi_q;
			else
				res_q <= v_q;
		end
		if (state_q == bggm_pkg::ST_FIX)
			res_q <= hi_minus_q ? hi_q - $signed(rem_rsp.rem) : lo_q + $signed(rem_rsp.rem);
		if (out_load) begin
			out_gene_q  <= res_q;
			out_mut_q   <= mutated_q;
			out_total_q <= total_q;
			out_last_q  <= last_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.new_gene      = out_gene_q;
	assign result.gene_mutated  = out_mut_q;
	assign result.mutated_total = out_total_q;
	assign result.last_out      = out_last_q;

`ifndef SYNTHESIS
	a_total_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last_out |-> result.mutated_total == '0)
		else $error("mutated_total set on a gene that is not last");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q <= bggm_pkg::HIT_CAP)
		else $error("hit count beyond cap");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> !item.ready)
		else $error("item taken while previous gene still in work");

	a_rem_to_fix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bggm_pkg::ST_DIV && rem_rsp.done |=> state_q == bggm_pkg::ST_FIX)
		else $error("remainder result not consumed");
`endif

endmodule

`default_nettype wire
